FILE: rtl/core/sdcg_pkg.sv
// sdcg_pkg: shared types and constants of the six-digit change grouper
// no dependencies; imported by sdcg_front, sdcg_back and six_digit_change_grouper_top
`default_nettype none

package sdcg_pkg;

    localparam int VALUE_W     = 20;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DRIVEN  = 6;
    localparam int MASK_W      = MAX_DRIVEN;
    localparam int IDX_W       = 3;

    localparam logic [DIGIT_W-1:0] DIGIT_BASE    = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX     = DIGIT_BASE - 4'd1;
    localparam logic [DIGIT_W-1:0] UNKNOWN_DIGIT = 4'hF;

    // divide by ten as multiply by ceil(2^23 / 10), exact for all 20-bit values
    localparam int RECIP_SHIFT = 23;
    localparam logic [VALUE_W-1:0] RECIP = 20'hCCCCD;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    localparam logic CMD_SHOW   = 1'b0;
    localparam logic CMD_FORGET = 1'b1;

    typedef logic [MAX_DRIVEN-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic    forget;
        t_digits digits;
    } t_job;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [MASK_W-1:0]  mask;
        logic               last;
    } t_update;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SPLIT,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/core/sdcg_fifo.sv
// sdcg_fifo: small register queue with first-word-fall-through read
// no dependencies
`default_nettype none

module sdcg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sdcg_front.sv
// sdcg_front: accepts beats, splits show values into decimal digits, one a cycle
// depends on sdcg_pkg
`default_nettype none

module sdcg_front #(
    parameter int NUM_DIGITS = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic                          i_command,
    input  wire logic [sdcg_pkg::VALUE_W-1:0]  i_time_value,
    output logic                               o_job_push,
    output sdcg_pkg::t_job                     o_job,
    input  wire logic                          i_job_full
);

    import sdcg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

    t_front_state          r_state;
    t_front_state          n_state;
    logic [VALUE_W-1:0]    r_value;
    logic [IDX_W-1:0]      r_cnt;
    logic                  r_forget;
    t_digits               r_digits;

    logic [PROD_W-1:0]     prod;
    logic [QUOT_W-1:0]     quot;
    logic [VALUE_W-1:0]    quot_ext;
    logic [VALUE_W-1:0]    quot_x10;
    logic [VALUE_W-1:0]    rem;
    logic                  accept;

    // one decimal digit per cycle: quotient by reciprocal, remainder by shift-add
    assign prod     = PROD_W'(r_value) * PROD_W'(RECIP);
    assign quot     = prod[PROD_W-1:RECIP_SHIFT];
    assign quot_ext = VALUE_W'(quot);
    assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
    assign rem      = r_value - quot_x10;

    assign accept = (r_state == FR_IDLE) && i_push;
    assign o_job  = '{forget: r_forget, digits: r_digits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        case (r_state)
            FR_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = (i_command == CMD_FORGET) ? FR_PUSH : FR_SPLIT;
                end
            end
            FR_SPLIT: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    n_state    = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value  <= i_time_value;
            r_forget <= i_command;
            r_cnt    <= '0;
            r_digits <= {MAX_DRIVEN{UNKNOWN_DIGIT}};
        end else if (r_state == FR_SPLIT) begin
            r_digits[r_cnt] <= rem[DIGIT_W-1:0];
            r_value         <= quot_ext;
            r_cnt           <= r_cnt + IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sdcg_back.sv
// sdcg_back: scans digit values 0..9 against the shown-digit store, forms updates
// depends on sdcg_pkg
`default_nettype none

module sdcg_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_empty,
    input  wire sdcg_pkg::t_job    i_job,
    output logic                   o_job_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output sdcg_pkg::t_update      o_res
);

    import sdcg_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    t_digits               r_shown;
    t_digits               r_digits;
    logic [DIGIT_W-1:0]    r_d;
    logic                  r_pend_valid;
    logic [DIGIT_W-1:0]    r_pend_digit;
    logic [MASK_W-1:0]     r_pend_mask;
    logic [MASK_W-1:0]     mask;
    logic                  step;

    always_comb begin
        for (int n = 0; n < MAX_DRIVEN; n++) begin
            mask[n] = (r_digits[n] == r_d) && (r_shown[n] != r_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // the held update goes out once a later one appears, or flagged last at the end
    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        step       = 1'b0;
        o_res      = '{digit: r_pend_digit, mask: r_pend_mask, last: 1'b0};
        case (r_state)
            BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    if (!i_job.forget) begin
                        n_state = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                if (!((mask != '0) && r_pend_valid && i_res_full)) begin
                    step       = 1'b1;
                    o_res_push = (mask != '0) && r_pend_valid;
                    if (r_d == DIGIT_MAX) begin
                        n_state = BK_FLUSH;
                    end
                end
            end
            BK_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = BK_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.last = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown      <= {MAX_DRIVEN{UNKNOWN_DIGIT}};
            r_pend_valid <= 1'b0;
        end else begin
            if (o_job_pop && i_job.forget) begin
                r_shown <= {MAX_DRIVEN{UNKNOWN_DIGIT}};
            end
            if (step && (mask != '0)) begin
                for (int n = 0; n < MAX_DRIVEN; n++) begin
                    if (mask[n]) begin
                        r_shown[n] <= r_d;
                    end
                end
                r_pend_valid <= 1'b1;
            end else if ((r_state == BK_FLUSH) && (n_state == BK_IDLE)) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_digits <= i_job.digits;
            r_d      <= '0;
        end else if (step) begin
            r_d <= r_d + DIGIT_W'(1);
            if (mask != '0) begin
                r_pend_digit <= r_d;
                r_pend_mask  <= mask;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/six_digit_change_grouper_top.sv
// six_digit_change_grouper_top: digit splitter, job queue, change scanner, result queue
// depends on sdcg_pkg, sdcg_fifo, sdcg_front, sdcg_back
//
// channel   direction  handshake                    payload
// -------   ---------  ---------------------------  ------------------------------------
// input     in         push / full (beat: push&!full)   i_command, i_time_value
// result    out        empty / pop (beat: pop&!empty)   o_digit, o_display_mask, o_last
//
// a show beat passes through the front, which splits min(NUM_DISPLAYS,6) digits one per
// cycle through a reciprocal multiplier, and the back (ten-step scan over digit values,
// one flush step); the back scan sets the sustained rate of show beats; a forget beat
// skips the split in the front and the scan in the back
// reset is synchronous, active low; every display reads as unknown after reset
// front and back stall separately behind a two-entry job queue; a full result
// queue stalls only the back, in its scan and flush steps
`default_nettype none

module six_digit_change_grouper_top #(
    parameter int NUM_DISPLAYS = 6
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               i_command,
    input  wire logic [sdcg_pkg::VALUE_W-1:0]       i_time_value,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic      [sdcg_pkg::DIGIT_W-1:0]       o_digit,
    output logic      [sdcg_pkg::MASK_W-1:0]        o_display_mask,
    output logic                                    o_last
);

    import sdcg_pkg::*;

    // only the first six displays are driven
    localparam int DRIVEN = (NUM_DISPLAYS > MAX_DRIVEN) ? MAX_DRIVEN : NUM_DISPLAYS;

    // front to job queue
    logic    job_push;
    t_job    job_in;
    logic    job_full;
    // job queue to back
    t_job    job_out;
    logic    job_empty;
    logic    job_pop;
    // back to result queue
    logic    res_push;
    t_update res_in;
    logic    res_full;
    t_update res_out;

    // front: accept and split into digits
    sdcg_front #(
        .NUM_DIGITS (DRIVEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_time_value (i_time_value),
        .o_job_push   (job_push),
        .o_job        (job_in),
        .i_job_full   (job_full)
    );

    // decoupling queue between front and back
    sdcg_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // back: compare with shown digits, group by digit value
    sdcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue facing the consumer
    sdcg_fifo #(
        .WIDTH ($bits(t_update)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_digit        = res_out.digit;
    assign o_display_mask = res_out.mask;
    assign o_last         = res_out.last;

`ifndef SYNTH
    // back never writes a result into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) res_push |-> !res_full)
        else $error("result written while result queue full");

    // front never writes a job into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) job_push |-> !job_full)
        else $error("job written while job queue full");

    // an accepted beat makes the front busy on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (push && !full) |=> full)
        else $error("front not busy after accepting a beat");

    // a waiting result carries a decimal digit and a nonempty mask
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_digit <= DIGIT_MAX) && (o_display_mask != '0)))
        else $error("malformed result at head of queue");
`endif

endmodule

`default_nettype wire
